// ----- rtl/histeq_pkg.sv -----
package histeq_pkg;

  // Histogram geometry
  localparam int unsigned BINS       = 256;
  localparam int unsigned BIN_W      = $clog2(BINS);
  localparam int unsigned PIX_W      = 8;

  // Pixel counter saturates at MAX_PIXELS
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);

  // Output levels and the scaled-numerator width (cum * LEVEL_MAX)
  localparam int unsigned LEVEL_MAX  = 255;
  localparam int unsigned NUM_W      = CNT_W + PIX_W;
  localparam int unsigned STEP_W     = $clog2(PIX_W);

  // Request opcodes
  localparam logic OP_ACC = 1'b0;
  localparam logic OP_MAP = 1'b1;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/histeq_ram.sv -----
module histeq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/histeq_div.sv -----
module histeq_div
  import histeq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [PIX_W-1:0]  quo_q, quo_d;
  logic [NUM_W-1:0]  trial;
  logic [CNT_W:0]    rem2;
  logic [CNT_W:0]    den_ext;
  logic              round_up;
  logic [PIX_W:0]    quo_rnd;

  // Restoring division, one quotient bit per cycle, MSB first
  assign trial = NUM_W'(den_q) << step_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(PIX_W - 1);
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d         = rem_q - trial;
        quo_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
  end

  // Round half to even on the final remainder, then clamp
  assign rem2     = {rem_q[CNT_W-1:0], 1'b0};
  assign den_ext  = {1'b0, den_q};
  assign round_up = (rem2 > den_ext) || ((rem2 == den_ext) && quo_q[0]);
  assign quo_rnd  = {1'b0, quo_q} + {{PIX_W{1'b0}}, round_up};

  assign rsp_o.done = done_q;
  assign rsp_o.quot = (quo_rnd > (PIX_W + 1)'(LEVEL_MAX)) ? PIX_W'(LEVEL_MAX)
                                                          : quo_rnd[PIX_W-1:0];

endmodule

// ----- rtl/histogram_equalizer_8bit_core.sv -----
// Accumulate request: accepted in IDLE, bin written in ACC_WR; map request with a built
// table: table read at accept, result registered in MAP_OUT when the output is free; no
// new request is taken until IDLE. The first map request after accumulation builds the
// table: a bin scan (SCAN_RD, SCAN_CHK) to the lowest nonempty bin, then CUM_RD, CUM_ACC
// and DIV_WAIT per later bin. Reset clears the pixel counter, the table flag and all
// histogram bin valid flags at once; no clearing pass runs, requests are taken right away.
module histogram_equalizer_8bit_core
  import histeq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             opcode_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] mapped_pixel_o,
  output logic             frame_done_o,
  output logic             empty_frame_o
);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] S_ACC_WR   = 4'd1;
  localparam logic [ST_W-1:0] S_SCAN_RD  = 4'd2;
  localparam logic [ST_W-1:0] S_SCAN_CHK = 4'd3;
  localparam logic [ST_W-1:0] S_CUM_RD   = 4'd4;
  localparam logic [ST_W-1:0] S_CUM_ACC  = 4'd5;
  localparam logic [ST_W-1:0] S_DIV_WAIT = 4'd6;
  localparam logic [ST_W-1:0] S_TBL_RD   = 4'd7;
  localparam logic [ST_W-1:0] S_MAP_OUT  = 4'd8;

  logic [ST_W-1:0]  state_q, state_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             ready_q, ready_d;
  logic [BINS-1:0]  bin_vld_q, bin_vld_d;
  logic             bin_vld_rd_q, bin_vld_rd_d;
  logic             flat_q, flat_d;
  logic [BIN_W-1:0] min_q, min_d;
  logic [BIN_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cum_q, cum_d;
  logic [PIX_W-1:0] px_q, px_d;
  logic             fe_q, fe_d;
  logic             empty_q, empty_d;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;
  logic             out_fe_q, out_fe_d;
  logic             out_empty_q, out_empty_d;

  logic             in_acc;
  logic             out_free;
  logic             bin_re, bin_we;
  logic [BIN_W-1:0] bin_raddr;
  logic [CNT_W-1:0] bin_rdata;
  logic [CNT_W-1:0] bin_count;
  logic             tbl_re, tbl_we;
  logic [BIN_W-1:0] tbl_raddr;
  logic [PIX_W-1:0] tbl_rdata;
  logic [CNT_W-1:0] cum_sum;
  logic [PIX_W-1:0] map_pix;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign bin_count  = bin_vld_rd_q ? bin_rdata : '0;
  assign cum_sum    = cum_q + bin_count;

  // Map through the table; empty frames and pixels at or below the lowest bin read 0, flat frames the lowest bin
  always_comb begin
    if (empty_q) begin
      map_pix = '0;
    end else if (flat_q) begin
      map_pix = min_q;
    end else if (px_q <= min_q) begin
      map_pix = '0;
    end else begin
      map_pix = tbl_rdata;
    end
  end

  // Sequencer: accumulate, table build, map
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    ready_d      = ready_q;
    bin_vld_d    = bin_vld_q;
    flat_d       = flat_q;
    min_d        = min_q;
    idx_d        = idx_q;
    den_d        = den_q;
    cum_d        = cum_q;
    px_d         = px_q;
    fe_d         = fe_q;
    empty_d      = empty_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_pix_d    = out_pix_q;
    out_fe_d     = out_fe_q;
    out_empty_d  = out_empty_q;
    bin_re       = 1'b0;
    bin_we       = 1'b0;
    bin_raddr    = idx_q;
    tbl_re       = 1'b0;
    tbl_we       = 1'b0;
    tbl_raddr    = px_q;
    div_req      = '0;
    div_req.num  = NUM_W'(cum_sum) * NUM_W'(LEVEL_MAX);
    div_req.den  = den_q;

    unique case (state_q)
      S_IDLE: begin
        bin_raddr = pixel_i;
        tbl_raddr = pixel_i;
        if (in_acc) begin
          px_d    = pixel_i;
          fe_d    = frame_end_i;
          empty_d = 1'b0;
          if (opcode_i == OP_ACC) begin
            ready_d = 1'b0;
            if (total_q < CNT_W'(MAX_PIXELS)) begin
              bin_re  = 1'b1;
              total_d = total_q + CNT_W'(1);
              state_d = S_ACC_WR;
            end
          end else if (total_q == '0) begin
            empty_d = 1'b1;
            state_d = S_MAP_OUT;
          end else if (ready_q) begin
            tbl_re  = 1'b1;
            state_d = S_MAP_OUT;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_ACC_WR: begin
        bin_we            = 1'b1;
        bin_vld_d[px_q]   = 1'b1;
        state_d           = S_IDLE;
      end
      S_SCAN_RD: begin
        bin_re  = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if ((bin_count != '0) || (idx_q == BIN_W'(BINS - 1))) begin
          min_d = idx_q;
          den_d = total_q - bin_count;
          cum_d = '0;
          if (total_q == bin_count) begin
            flat_d  = 1'b1;
            ready_d = 1'b1;
            state_d = S_TBL_RD;
          end else begin
            flat_d = 1'b0;
            if (idx_q == BIN_W'(BINS - 1)) begin
              ready_d = 1'b1;
              state_d = S_TBL_RD;
            end else begin
              idx_d   = idx_q + BIN_W'(1);
              state_d = S_CUM_RD;
            end
          end
        end else begin
          idx_d   = idx_q + BIN_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_CUM_RD: begin
        bin_re  = 1'b1;
        state_d = S_CUM_ACC;
      end
      S_CUM_ACC: begin
        cum_d         = cum_sum;
        div_req.start = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          tbl_we = 1'b1;
          if (idx_q == BIN_W'(BINS - 1)) begin
            ready_d = 1'b1;
            state_d = S_TBL_RD;
          end else begin
            idx_d   = idx_q + BIN_W'(1);
            state_d = S_CUM_RD;
          end
        end
      end
      S_TBL_RD: begin
        tbl_re  = 1'b1;
        state_d = S_MAP_OUT;
      end
      S_MAP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = map_pix;
          out_fe_d    = fe_q;
          out_empty_d = empty_q;
          state_d     = S_IDLE;
          // Drop the frame at its last map request
          if (fe_q) begin
            bin_vld_d = '0;
            total_d   = '0;
            ready_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign bin_vld_rd_d = bin_re ? bin_vld_q[bin_raddr] : bin_vld_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      ready_q     <= 1'b0;
      bin_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ready_q     <= ready_d;
      bin_vld_q   <= bin_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_vld_rd_q <= bin_vld_rd_d;
    flat_q       <= flat_d;
    min_q        <= min_d;
    idx_q        <= idx_d;
    den_q        <= den_d;
    cum_q        <= cum_d;
    px_q         <= px_d;
    fe_q         <= fe_d;
    empty_q      <= empty_d;
    out_pix_q    <= out_pix_d;
    out_fe_q     <= out_fe_d;
    out_empty_q  <= out_empty_d;
  end

  // Histogram bins
  histeq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (px_q),
    .wdata_i (bin_count + CNT_W'(1)),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // Remap table
  histeq_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BINS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx_q),
    .wdata_i (div_rsp.quot),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Table entry divider
  histeq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign mapped_pixel_o = out_pix_q;
  assign frame_done_o   = out_fe_q;
  assign empty_frame_o  = out_empty_q;

endmodule
